FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the relay sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// Relay switch sequencer package
// Opcodes, field widths and reset constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package rss_pkg;

   localparam int OPCODE_WIDTH     = 3;
   localparam int MASK_WIDTH       = 16;
   localparam int REQ_TDATA_WIDTH  = 24;
   localparam int RSP_TDATA_WIDTH  = 24;

   localparam logic [MASK_WIDTH-1:0] EXCLUSIVE_MASK_RESET = 16'h0003;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ON           = 3'd0,
      OP_OFF          = 3'd1,
      OP_ALL_OFF      = 3'd2,
      OP_PROCESS_EXCL = 3'd3,
      OP_PROCESS_CONC = 3'd4,
      OP_QUERY        = 3'd5
   } opcode_type;

endpackage

FILE: rtl/rss_update.sv
// ----------------------------------------------------------------------------
// Relay state update
// Next command and drive words for one transaction, plus its result fields.
// ----------------------------------------------------------------------------
module rss_update
   import rss_pkg::*;
#(
   parameter int RELAY_COUNT = 16
) (
   input  logic [OPCODE_WIDTH-1:0] opcode,
   input  logic [MASK_WIDTH-1:0]   relay_mask,
   input  logic [MASK_WIDTH-1:0]   exclusive_mask,
   input  logic [RELAY_COUNT-1:0]  excl_command,
   input  logic [RELAY_COUNT-1:0]  conc_command,
   input  logic [RELAY_COUNT-1:0]  excl_drive,
   input  logic [RELAY_COUNT-1:0]  conc_drive,
   output logic [RELAY_COUNT-1:0]  excl_command_next,
   output logic [RELAY_COUNT-1:0]  conc_command_next,
   output logic [RELAY_COUNT-1:0]  excl_drive_next,
   output logic [RELAY_COUNT-1:0]  conc_drive_next,
   output logic [MASK_WIDTH-1:0]   relay_drive,
   output logic                    all_commanded_on
);

   logic [RELAY_COUNT-1:0] req_bits;
   logic [RELAY_COUNT-1:0] excl_group;
   logic [RELAY_COUNT-1:0] req_excl;
   logic [RELAY_COUNT-1:0] req_conc;
   logic [RELAY_COUNT-1:0] kept_drive;
   logic [RELAY_COUNT-1:0] pending;
   logic [RELAY_COUNT-1:0] lowest_pending;
   logic [RELAY_COUNT-1:0] command_all;
   logic [RELAY_COUNT-1:0] drive_all;

   // Relays above the mask width are never named and always concurrent.
   for (genvar i = 0; i < RELAY_COUNT; i++) begin : g_bits
      if (i < MASK_WIDTH) begin : g_named
         assign req_bits[i]   = relay_mask[i];
         assign excl_group[i] = exclusive_mask[i];
      end else begin : g_unnamed
         assign req_bits[i]   = 1'b0;
         assign excl_group[i] = 1'b0;
      end
   end

   assign req_excl       = req_bits & excl_group;
   assign req_conc       = req_bits & ~excl_group;
   assign kept_drive     = excl_drive & excl_command;
   assign pending        = excl_command & ~kept_drive;
   assign lowest_pending = pending & (~pending + RELAY_COUNT'(1));

   always_comb begin
      excl_command_next = excl_command;
      conc_command_next = conc_command;
      excl_drive_next   = excl_drive;
      conc_drive_next   = conc_drive;
      unique case (opcode_type'(opcode))
         OP_ON: begin
            if (|req_excl) begin
               excl_command_next = excl_command | req_excl;
            end else begin
               conc_command_next = conc_command | req_conc;
            end
         end
         OP_OFF: begin
            if (|req_excl) begin
               excl_command_next = excl_command & ~req_excl;
            end else begin
               conc_command_next = conc_command & ~req_conc;
            end
         end
         OP_ALL_OFF: begin
            excl_command_next = '0;
            conc_command_next = '0;
         end
         OP_PROCESS_EXCL: begin
            // drop uncommanded drive, then switch on the lowest waiting relay
            excl_drive_next = kept_drive | lowest_pending;
         end
         OP_PROCESS_CONC: begin
            conc_drive_next = conc_command;
         end
         default: begin
         end
      endcase
   end

   assign command_all      = excl_command_next | conc_command_next;
   assign drive_all        = excl_drive_next | conc_drive_next;
   assign all_commanded_on = ((command_all & req_bits) == req_bits);

   for (genvar j = 0; j < MASK_WIDTH; j++) begin : g_drive
      if (j < RELAY_COUNT) begin : g_present
         assign relay_drive[j] = drive_all[j];
      end else begin : g_absent
         assign relay_drive[j] = 1'b0;
      end
   end

endmodule

FILE: rtl/relay_switch_sequencer.sv
// ----------------------------------------------------------------------------
// Relay switch sequencer
// Keeps relay command and drive words and answers every request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tdata[2:0] opcode, tdata[18:3] relay mask. Opcodes turn
//   relays on or off, clear all commands, advance the exclusive group (one
//   relay switched on per step) or the concurrent group (all commanded relays
//   driven at once), or only query.
//   rsp channel: one transaction per request, tdata[15:0] drive word after
//   the request, tdata[16] set when every masked relay is commanded on.
//   csr port: csr_wr_en writes csr_wr_data into the exclusive group mask;
//   write it only while no request is in flight.
//   A request passes through the input register, then through the update logic
//   into the result register, which drives the response. Throughput is one
//   transaction per cycle while the receiver takes responses, set by the single
//   update pass over the command and drive registers.
//   Reset clears all command and drive bits, empties both registers and sets
//   the group mask to relays 0 and 1. When the receiver stalls, the response
//   holds and one more request still fits in the input register; after that
//   req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
module relay_switch_sequencer
   import rss_pkg::*;
#(
   parameter int RELAY_COUNT = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,   // opcode[2:0], relay_mask[18:3], zero pad
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,   // relay_drive[15:0], all_commanded_on[16], pad
   input  logic                       csr_wr_en,
   input  logic [MASK_WIDTH-1:0]      csr_wr_data
);

   logic                    in_valid_ff, in_valid_in;
   logic [OPCODE_WIDTH-1:0] in_opcode_ff;
   logic [MASK_WIDTH-1:0]   in_mask_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [MASK_WIDTH-1:0]   out_drive_ff;
   logic                    out_all_on_ff;
   logic [MASK_WIDTH-1:0]   excl_mask_ff;

   logic [RELAY_COUNT-1:0] excl_command_ff, excl_command_in;
   logic [RELAY_COUNT-1:0] conc_command_ff, conc_command_in;
   logic [RELAY_COUNT-1:0] excl_drive_ff, excl_drive_in;
   logic [RELAY_COUNT-1:0] conc_drive_ff, conc_drive_in;
   logic [MASK_WIDTH-1:0]  drive_result;
   logic                   all_on_result;

   logic out_ready;
   logic advance;
   logic req_take;

   assign out_ready   = !out_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && out_ready;
   assign req_tready  = !in_valid_ff || out_ready;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !out_ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   rss_update #(
      .RELAY_COUNT(RELAY_COUNT)
   ) update_inst (
      .opcode            (in_opcode_ff),
      .relay_mask        (in_mask_ff),
      .exclusive_mask    (excl_mask_ff),
      .excl_command      (excl_command_ff),
      .conc_command      (conc_command_ff),
      .excl_drive        (excl_drive_ff),
      .conc_drive        (conc_drive_ff),
      .excl_command_next (excl_command_in),
      .conc_command_next (conc_command_in),
      .excl_drive_next   (excl_drive_in),
      .conc_drive_next   (conc_drive_in),
      .relay_drive       (drive_result),
      .all_commanded_on  (all_on_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         excl_mask_ff    <= EXCLUSIVE_MASK_RESET;
         excl_command_ff <= '0;
         conc_command_ff <= '0;
         excl_drive_ff   <= '0;
         conc_drive_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            excl_mask_ff <= csr_wr_data;
         end
         // commit state only when the transaction moves to the result register
         if (advance) begin
            excl_command_ff <= excl_command_in;
            conc_command_ff <= conc_command_in;
            excl_drive_ff   <= excl_drive_in;
            conc_drive_ff   <= conc_drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_tdata[OPCODE_WIDTH-1:0];
         in_mask_ff   <= req_tdata[OPCODE_WIDTH +: MASK_WIDTH];
      end
      if (advance) begin
         out_drive_ff  <= drive_result;
         out_all_on_ff <= all_on_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_WIDTH-MASK_WIDTH-1)'(0), out_all_on_ff, out_drive_ff};

endmodule

FILE: rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// Relay switch sequencer checker
// Port-level timing checks on the request and response channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rss_checker
   import rss_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")
   `ASSERT_IMPLIES(a_ready_when_free, clock, reset, !rsp_tvalid, req_tready, "request stalled with empty response")
   `ASSERT_NEXT(a_latency, clock, reset, req_fire ##1 rsp_tready, rsp_tvalid, "response missing two cycles after request")

endmodule

bind relay_switch_sequencer rss_checker checker_inst (.*);

FILE: test/relay_switch_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Relay switch sequencer testbench
// Drives request transactions with random gaps and response stalls, predicts
// every response from a local copy of the command, drive and group-mask
// state, and checks each response field against the oldest prediction.
// Covers directed corner cases, regrouping of stored bits, and random traffic
// under several exclusive-group masks.
// ----------------------------------------------------------------------------
module relay_switch_sequencer_tb;
   import rss_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [MASK_WIDTH-1:0] drive;
      logic                  all_on;
   } relay_answer_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;   // opcode[2:0], relay_mask[18:3], zero pad
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;        // relay_drive[15:0], all_commanded_on[16], pad
   logic                       csr_wr_en = 1'b0;
   logic [MASK_WIDTH-1:0]      csr_wr_data = '0;

   // Local copy of the sequencer state
   logic [MASK_WIDTH-1:0] group_mask = EXCLUSIVE_MASK_RESET;
   logic [MASK_WIDTH-1:0] excl_cmd = '0;
   logic [MASK_WIDTH-1:0] conc_cmd = '0;
   logic [MASK_WIDTH-1:0] excl_drv = '0;
   logic [MASK_WIDTH-1:0] conc_drv = '0;

   relay_answer_type pending_answers[$];

   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int cycle_count = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int answers_checked = 0;
   int mask_settings = 0;

   relay_switch_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Apply one request to the local state and return the response it owes
   function automatic relay_answer_type apply_relay_request(input logic [2:0] op,
                                                            input logic [MASK_WIDTH-1:0] mask);
      logic [MASK_WIDTH-1:0] ex_grp;
      logic [MASK_WIDTH-1:0] con_grp;
      logic [MASK_WIDTH-1:0] waiting;
      relay_answer_type      ans;
      ex_grp = group_mask;
      con_grp = ~group_mask;
      case (op)
         OP_ON: begin
            if ((mask & ex_grp) != '0) excl_cmd = excl_cmd | (mask & ex_grp);
            else conc_cmd = conc_cmd | (mask & con_grp);
         end
         OP_OFF: begin
            if ((mask & ex_grp) != '0) excl_cmd = excl_cmd & ~(mask & ex_grp);
            else conc_cmd = conc_cmd & ~(mask & con_grp);
         end
         OP_ALL_OFF: begin
            excl_cmd = '0;
            conc_cmd = '0;
         end
         OP_PROCESS_EXCL: begin
            excl_drv = excl_drv & excl_cmd;
            waiting = excl_cmd & ~excl_drv;
            // switch on only the lowest waiting relay
            excl_drv = excl_drv | (waiting & (~waiting + MASK_WIDTH'(1)));
         end
         OP_PROCESS_CONC: begin
            conc_drv = conc_cmd;
         end
         default: begin
         end
      endcase
      ans.drive = excl_drv | conc_drv;
      ans.all_on = (((excl_cmd | conc_cmd) & mask) == mask);
      return ans;
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [MASK_WIDTH-1:0] mask);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_TDATA_WIDTH - MASK_WIDTH - OPCODE_WIDTH){1'b0}}, mask, op};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(apply_relay_request(op, mask));
      requests_sent++;
   endtask

   // Hold the request side until every expected response has come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_group_mask(input logic [MASK_WIDTH-1:0] value);
      hold_until_drained();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      group_mask = value;
      mask_settings++;
   endtask

   // Response side: when stalls are on, stall a random number of cycles before each transaction
   initial begin
      int stall;
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 12) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   always @(posedge clock) begin
      relay_answer_type exp_ans;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: drive %h all_on %b",
                        rsp_tdata[15:0], rsp_tdata[16]);
         end else begin
            exp_ans = pending_answers.pop_front();
            answers_checked++;
            if (rsp_tdata[15:0] !== exp_ans.drive || rsp_tdata[16] !== exp_ans.all_on) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("response %0d mismatch: drive exp %h got %h, all_on exp %b got %b",
                           answers_checked, exp_ans.drive, rsp_tdata[15:0],
                           exp_ans.all_on, rsp_tdata[16]);
            end
         end
      end
   end

   function automatic logic [2:0] pick_opcode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return OP_ON;
      if (r < 40) return OP_OFF;
      if (r < 45) return OP_ALL_OFF;
      if (r < 65) return OP_PROCESS_EXCL;
      if (r < 80) return OP_PROCESS_CONC;
      if (r < 95) return OP_QUERY;
      return 3'($urandom_range(6, 7));
   endfunction

   function automatic logic [MASK_WIDTH-1:0] pick_mask();
      logic [MASK_WIDTH-1:0] m;
      m = MASK_WIDTH'($urandom);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return MASK_WIDTH'(1) << $urandom_range(0, MASK_WIDTH - 1);
         // keep the request inside one group so both paths see traffic
         3, 4: return m & group_mask;
         5: return m & ~group_mask;
         default: return m;
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_QUERY, 16'h0000);
      send_request(OP_QUERY, 16'hFFFF);
      send_request(OP_ON, 16'h0000);
      send_request(OP_ON, 16'h0001);
      send_request(OP_ON, 16'hFFFF);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_ON, 16'hFFFC);
      send_request(OP_PROCESS_CONC, 16'h0000);
      send_request(OP_QUERY, 16'hFFFF);
      send_request(OP_OFF, 16'h8000);
      send_request(OP_OFF, 16'h0000);
      send_request(OP_PROCESS_CONC, 16'hFFFF);
      send_request(3'd6, 16'hFFFF);
      send_request(3'd7, 16'h5555);
      send_request(OP_OFF, 16'h0001);
      send_request(OP_PROCESS_EXCL, 16'hAAAA);
      send_request(OP_ALL_OFF, 16'hFFFF);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_CONC, 16'h0000);
      send_request(OP_QUERY, 16'h0000);
   endtask

   // Stored bits keep their word when the group mask moves under them
   task automatic test_regroup();
      send_request(OP_ON, 16'h000F);
      send_request(OP_ON, 16'h00FC);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_CONC, 16'h0000);
      write_group_mask(16'h00F0);
      send_request(OP_QUERY, 16'h00FF);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_ON, 16'h00F3);
      send_request(OP_OFF, 16'h0003);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_CONC, 16'hFFFF);
      send_request(OP_ALL_OFF, 16'h0000);
      send_request(OP_PROCESS_EXCL, 16'h0000);
      send_request(OP_PROCESS_CONC, 16'h0000);
   endtask

   task automatic test_random_traffic(input logic [MASK_WIDTH-1:0] grp, input int count,
                                      input bit gaps, input bit stalls, input bit pause);
      write_group_mask(grp);
      req_gaps_on = gaps;
      rsp_stalls_on = stalls;
      for (int i = 0; i < count; i++) begin
         if (pause && i == count / 2) hold_until_drained();
         send_request(pick_opcode(), pick_mask());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_regroup();
      test_random_traffic(16'h0000, 220, 1'b1, 1'b1, 1'b1);
      test_random_traffic(16'hFFFF, 220, 1'b0, 1'b1, 1'b0);
      test_random_traffic(EXCLUSIVE_MASK_RESET, 220, 1'b1, 1'b0, 1'b0);
      test_random_traffic(16'h8001, 220, 1'b0, 1'b0, 1'b0);
      test_random_traffic(MASK_WIDTH'($urandom), 220, 1'b1, 1'b1, 1'b0);
      test_random_traffic(MASK_WIDTH'($urandom), 220, 1'b1, 1'b1, 1'b1);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d requests under %0d group masks, checked %0d responses",
               requests_sent, mask_settings + 1, answers_checked);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
